### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

### rtl/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Constants, types and codes of the bimodal insertion replacement block.
// ----------------------------------------------------------------------------
package bir_pkg;

   // Cache geometry
   localparam int SETS     = 2048;
   localparam int WAYS     = 16;
   localparam int SET_W    = $clog2(SETS);
   localparam int WAY_W    = $clog2(WAYS);

   // Field widths
   localparam int SETIDX_W = 11;
   localparam int WAYIDX_W = 4;
   localparam int STAMP_W  = 32;
   localparam int VICTIM_W = 4;
   localparam int THR_W    = 16;

   // Insertion LFSR (Galois, maximal length)
   localparam int LFSR_W = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   // Minimum-search tree
   localparam int LVLS   = $clog2(WAYS);
   localparam int TREE_W = 1 << LVLS;
   localparam int LVL_W  = $clog2(LVLS + 1);

   typedef enum logic {
      CMD_QUERY  = 1'b0,
      CMD_UPDATE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_DONE
   } state_type;

   // One way of a set row
   typedef struct packed {
      logic               lru;
      logic [STAMP_W-1:0] stamp;
   } way_ent_type;

   typedef way_ent_type [WAYS-1:0] row_type;

   // Node of the minimum-search tree
   typedef struct packed {
      logic               vld;
      logic [STAMP_W-1:0] stamp;
      logic [WAY_W-1:0]   way;
   } node_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic exec_upd;
      logic load_tree;
      logic tree_step;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_query;
      logic rsp_free;
   } ctl_sts_type;

endpackage

### rtl/bir_ifs.sv
// ----------------------------------------------------------------------------
// bir channel interfaces
// Valid/ready channels for requests and victim responses.
// ----------------------------------------------------------------------------
interface bir_req_if
   import bir_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SETIDX_W-1:0] set_index;
   logic [WAYIDX_W-1:0] way_index;
   logic                was_hit;
   logic [STAMP_W-1:0]  cycle_stamp;

   modport source (output valid, cmd, set_index, way_index, was_hit, cycle_stamp,
                   input ready);
   modport sink   (input valid, cmd, set_index, way_index, was_hit, cycle_stamp,
                   output ready);
endinterface

interface bir_rsp_if
   import bir_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [VICTIM_W-1:0] victim_way;

   modport source (output valid, victim_way, input ready);
   modport sink   (input valid, victim_way, output ready);
endinterface

### rtl/bimodal_insertion_replacement_top.sv
// ----------------------------------------------------------------------------
// bimodal_insertion_replacement_top
// BIP replacement state for a 2048-set, 16-way cache: victim query and update.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_if    in   valid/ready        cmd, set_index, way_index, was_hit,
//                                    cycle_stamp
//  rsp_if    out  valid/ready        victim_way
//  csr_*     in   csr_wr_en          csr_wr_data (LRU insertion threshold)
//
//  An update reads the set row into a register, then modifies it and writes
//  it back. A victim query reads the row, loads it into a 2:1 minimum tree,
//  steps the tree once per level, then fills the response register. The row
//  memory and the tree are shared, so one request is handled at a time.
//  After reset, a clearing pass writes one row per cycle, all SETS (2048)
//  rows, before the first request is accepted; csr writes are taken meanwhile.
//  A stalled response holds in its register; a new request is accepted while
//  it waits, and only the next query's result waits for the slot.
// ----------------------------------------------------------------------------
module bimodal_insertion_replacement_top
   import bir_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   bir_req_if.sink            req_if,
   bir_rsp_if.source          rsp_if,
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;
   logic        req_ready;

   assign req_if.ready = req_ready;

   bir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (ctl_sts),
      .cmd       (ctl_cmd)
   );

   bir_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctl_cmd),
      .sts             (ctl_sts),
      .req_cmd         (req_if.cmd),
      .req_set_index   (req_if.set_index),
      .req_way_index   (req_if.way_index),
      .req_was_hit     (req_if.was_hit),
      .req_cycle_stamp (req_if.cycle_stamp),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_victim_way  (rsp_if.victim_way),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

endmodule

### rtl/bir_ctrl.sv
// ----------------------------------------------------------------------------
// bir_ctrl
// Sequencer: clearing pass, request accept, row update or minimum search.
// ----------------------------------------------------------------------------
module bir_ctrl
   import bir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   // State and level counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_query) begin
               cmd.load_tree = 1'b1;
               lvl_in        = '0;
               state_in      = ST_SEARCH;
            end else begin
               cmd.exec_upd = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            cmd.tree_step = 1'b1;
            if (lvl_ff == LVL_W'(LVLS - 1)) begin
               state_in = ST_DONE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

### rtl/bir_dpath.sv
// ----------------------------------------------------------------------------
// bir_dpath
// Set-row memory, item registers, insertion LFSR, minimum tree, response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bir_dpath
   import bir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output ctl_sts_type         sts,
   // request payload
   input  logic                req_cmd,
   input  logic [SETIDX_W-1:0] req_set_index,
   input  logic [WAYIDX_W-1:0] req_way_index,
   input  logic                req_was_hit,
   input  logic [STAMP_W-1:0]  req_cycle_stamp,
   // response
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VICTIM_W-1:0] rsp_victim_way,
   // threshold register
   input  logic                csr_wr_en,
   input  logic [THR_W-1:0]    csr_wr_data
);

   // One row per set: flag and stamp of every way
   row_type             row_mem [SETS];
   row_type             rd_row_ff;
   row_type             wr_row;

   logic [SET_W-1:0]    clr_ff;
   cmd_type             cmd_ff;
   logic [SET_W-1:0]    set_ff;
   logic [WAYIDX_W-1:0] way_ff;
   logic                hit_ff;
   logic [STAMP_W-1:0]  stamp_ff;
   logic [THR_W-1:0]    thr_ff;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic                rsp_valid_ff;
   logic [VICTIM_W-1:0] victim_ff;
   node_type            node_ff [TREE_W];
   node_type            node_in [TREE_W];
   logic [SET_W-1:0]    rd_addr;
   logic [WAY_W-1:0]    way_sel;
   logic                way_ok;
   logic                to_lru;
   logic [31:0]         root_way;

   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] r;
      r = s >> 1;
      if (s[0]) r = r ^ LFSR_TAPS;
      return r;
   endfunction

   // Lower node wins ties; an invalid node never wins over a valid one
   function automatic node_type pick_min(input node_type a, input node_type b);
      node_type r;
      r = a;
      if (b.vld && (!a.vld || (b.stamp < a.stamp))) r = b;
      return r;
   endfunction

   // Set number modulo SETS (power of two: low bits)
   assign rd_addr = req_set_index[SET_W-1:0];

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Item registers, captured on the accepted transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff   <= cmd_type'(req_cmd);
         set_ff   <= rd_addr;
         way_ff   <= req_way_index;
         hit_ff   <= req_was_hit;
         stamp_ff <= req_cycle_stamp;
      end
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Fill decision: LFSR steps on every fill, new value is compared
   assign lfsr_in = lfsr_next(lfsr_ff);
   assign to_lru  = lfsr_in < thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else if (cmd.exec_upd && !hit_ff) begin
         lfsr_ff <= lfsr_in;
      end
   end

   // Row modify for an update
   assign way_ok  = 32'(way_ff) < 32'(WAYS);
   assign way_sel = WAY_W'(way_ff);

   always_comb begin
      wr_row = rd_row_ff;
      if (way_ok) begin
         if (hit_ff) begin
            if (rd_row_ff[way_sel].lru) begin
               wr_row[way_sel].lru   = 1'b0;
               wr_row[way_sel].stamp = stamp_ff;
            end
         end else if (to_lru) begin
            wr_row[way_sel].lru = 1'b1;
         end else begin
            wr_row[way_sel].lru   = 1'b0;
            wr_row[way_sel].stamp = stamp_ff;
         end
      end
   end

   // Row memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         for (int i = 0; i < WAYS; i++) begin
            row_mem[clr_ff][i] <= '{lru: 1'b1, stamp: '0};
         end
      end else if (cmd.exec_upd) begin
         row_mem[set_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   // Minimum tree: load leaves, then halve in place once per step
   always_comb begin
      for (int i = 0; i < TREE_W; i++) begin
         node_in[i] = node_ff[i];
      end
      if (cmd.load_tree) begin
         for (int i = 0; i < TREE_W; i++) begin
            node_in[i].vld   = (i < WAYS);
            node_in[i].stamp = (i < WAYS) ? rd_row_ff[i].stamp : '0;
            node_in[i].way   = WAY_W'(i);
         end
      end else if (cmd.tree_step) begin
         for (int i = 0; i < TREE_W / 2; i++) begin
            node_in[i] = pick_min(node_ff[2*i], node_ff[2*i+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TREE_W; i++) begin
         node_ff[i] <= node_in[i];
      end
   end

   // Response register
   assign root_way = 32'(node_ff[0].way);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         victim_ff <= root_way[VICTIM_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = victim_ff;

   // Status
   assign sts.clear_last = (clr_ff == SET_W'(SETS - 1));
   assign sts.is_query   = (cmd_ff == CMD_QUERY);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Checks
   `ASSERT_CLK_RST(a_upd_only_for_update, clock, reset, cmd.exec_upd |-> cmd_ff == CMD_UPDATE, "row write-back issued for a victim query")
   `ASSERT_CLK_RST(a_root_valid, clock, reset, cmd.tree_step |=> node_ff[0].vld, "tree root holds no valid way")
   `ASSERT_CLK_RST(a_rsp_loaded, clock, reset, cmd.load_rsp |=> rsp_valid_ff, "response load did not raise valid")

endmodule
